FILE: design/smpq_pkg.sv
// shared types and codes for the sorted priority queue
package smpq_pkg;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] prio;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

FILE: design/smpq_cell.sv
// one slot of the sorted chain: keeps, takes the new entry or shifts from a neighbor
module smpq_cell
  import smpq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  logic       occ_i,
  input  entry_t     left_i,
  input  logic       left_keep_i,
  input  entry_t     right_i,
  output entry_t     ent_o,
  output logic       keep_o
);

  entry_t ent_q, ent_d;

  // held entry stays ahead of the new one when its priority is not larger
  assign keep_o = occ_i && ($signed(ent_q.prio) <= $signed(new_i.prio));

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        ent_d = left_keep_i ? new_i : left_i;
      end
    end else if (ctrl_i.rem) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

FILE: design/stable_min_priority_queue.sv
// top level of the sorted priority queue built as a chain of slot cells
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | mode_i, value_i, prio_i
//   out     | output    | out_valid_o/out_ready_i | status_o, head_value_o,
//           |           |                         | head_prio_o, occupancy_o
//
// every item is handled in the cycle it is accepted; its result shows in the next cycle
// all cells compare against the new priority at once, so one item per cycle is sustained while results are taken
// in_ready_o drops only while a result waits and out_ready_i is low
// reset clears the fill count and the result valid flag; slot contents are left as is
module stable_min_priority_queue
  import smpq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] value_i,
  input  logic [15:0] prio_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] head_value_o,
  output logic [15:0] head_prio_o,
  output logic [4:0]  occupancy_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [31:0]     head_value_q, head_value_d;
  logic [15:0]     head_prio_q, head_prio_d;
  logic [4:0]      occupancy_q;

  logic       accept;
  logic       empty, full;
  cell_ctrl_t ctrl;
  entry_t     new_ent;
  entry_t     ent   [DEPTH];
  logic       keep  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntW'(DEPTH));

  assign ctrl.ins      = accept && (mode_i == MODE_INSERT) && !full;
  assign ctrl.rem      = accept && (mode_i == MODE_REMOVE) && !empty;
  assign new_ent.value = value_i;
  assign new_ent.prio  = prio_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_keep;

    if (i == 0) begin : g_first
      assign left_ent  = new_ent;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_keep = keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = new_ent;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_i       (new_ent),
      .occ_i       (CntW'(i) < count_q),
      .left_i      (left_ent),
      .left_keep_i (left_keep),
      .right_i     (right_ent),
      .ent_o       (ent[i]),
      .keep_o      (keep[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    status_d     = ST_OK;
    head_value_d = '0;
    head_prio_d  = '0;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d      = count_q - CntW'(1);
      head_value_d = ent[0].value;
      head_prio_d  = ent[0].prio;
    end else if (mode_i == MODE_INSERT) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      head_value_q <= head_value_d;
      head_prio_q  <= head_prio_d;
      occupancy_q  <= 5'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign head_value_o = head_value_q;
  assign head_prio_o  = head_prio_q;
  assign occupancy_o  = occupancy_q;

endmodule

FILE: design/smpq_checker.sv
// port-level checks for the sorted priority queue
module smpq_checker
  import smpq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        mode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] head_value_o,
  input logic [15:0] head_prio_o,
  input logic [4:0]  occupancy_o
);

  // every accepted item yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted item");

  // a waiting result blocks the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  // removal from empty leaves an empty queue and zero fields
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |->
      occupancy_o == 5'd0 && head_value_o == '0 && head_prio_o == '0)
    else $error("bad empty removal result");

  // a dropped insert reports a full queue
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      occupancy_o == 5'(DEPTH) && head_value_o == '0 && head_prio_o == '0)
    else $error("bad full insert result");

  // an accepted insert is never answered as an empty removal
  a_insert_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == MODE_INSERT |=>
      status_o == ST_OK || status_o == ST_FULL)
    else $error("insert answered with removal status");

endmodule

bind stable_min_priority_queue smpq_checker #(.DEPTH(DEPTH)) u_smpq_checker (.*);
